// ===== hdl/eat_pkg.sv =====
// ----------------------------------------------------------------------------
// eat_pkg
// Shared types, constants and the arctangent table for the elliptical arc
// tessellator.
// ----------------------------------------------------------------------------
package eat_pkg;

  localparam int SEGMENTS_PER_TURN = 48;
  localparam int ROTATION_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES = 24;

  localparam int MAX_STEPS = 62;
  localparam int STEPS_W = 6;
  localparam int MAG_W = 21;
  localparam int ANGLE_W = 22;
  localparam int ACC_W = 42;
  localparam int ROT_W = 33;     // cordic x, y, z in Q30
  localparam int TRIG_W = 27;    // sine/cosine in Q24
  localparam int SCALE_W = 34;   // direction times radius, Q16

  localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;
  localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ROT_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEPS,
    ST_DIV,
    ST_RUN
  } eat_state_e;

  // one cordic stage's worth of data
  typedef struct packed {
    logic                    valid;
    logic                    neg;
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] z;
  } eat_rot_t;

  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'd843314857;
      1:  v = 32'd497837829;
      2:  v = 32'd263043837;
      3:  v = 32'd133525159;
      4:  v = 32'd67021687;
      5:  v = 32'd33543516;
      6:  v = 32'd16775851;
      7:  v = 32'd8388437;
      8:  v = 32'd4194283;
      9:  v = 32'd2097149;
      10: v = 32'd1048576;
      11: v = 32'd524288;
      12: v = 32'd262144;
      13: v = 32'd131072;
      14: v = 32'd65536;
      15: v = 32'd32768;
      16: v = 32'd16384;
      17: v = 32'd8192;
      18: v = 32'd4096;
      19: v = 32'd2048;
      20: v = 32'd1024;
      21: v = 32'd512;
      22: v = 32'd256;
      23: v = 32'd128;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/ellipse_arc_tessellator_unit.sv =====
// ----------------------------------------------------------------------------
// ellipse_arc_tessellator_unit
// Turns one elliptical arc request into a polyline of up to 63 points.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | in        | in_valid_i/in_stall_o | center, direction, radii, angles
//  out     | out       | out_valid_o/out_stall_i | point_x/y, point_index, last_point
//
// Setup per arc: a step count search, then a divider.
// Each point passes reduction, ROTATION_STEPS cordic cells, rounding, products
// and the output register; the next point issues the cycle after it is taken,
// so one point is in flight at a time.
// A stall on the output holds the current point and the next issue.
// Reset clears control state; in_stall_o is low once reset is released.
// ----------------------------------------------------------------------------
module ellipse_arc_tessellator_unit import eat_pkg::*; #(
  parameter int ROTATION_STEPS = ROTATION_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [17:0] dir_x_i,
  input  logic signed [17:0] dir_y_i,
  input  logic        [30:0] major_len_i,
  input  logic        [30:0] minor_len_i,
  input  logic signed [19:0] angle_from_i,
  input  logic signed [19:0] angle_to_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic        [5:0]  point_index_o,
  output logic               last_point_o
);

  eat_state_e state_q, state_d;

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // request registers
  logic signed [31:0] cx_q, cy_q;
  logic signed [17:0] dx_q, dy_q;
  logic        [30:0] rmaj_q, rmin_q;
  logic signed [19:0] a0_q;
  logic [MAG_W-1:0]   mag_q;
  logic               sneg_q;

  logic signed [MAG_W-1:0] sweep;
  assign sweep = MAG_W'(angle_to_i) - MAG_W'(angle_from_i);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cx_q   <= center_x_i;
      cy_q   <= center_y_i;
      dx_q   <= dir_x_i;
      dy_q   <= dir_y_i;
      rmaj_q <= major_len_i;
      rmin_q <= minor_len_i;
      a0_q   <= angle_from_i;
      sneg_q <= sweep[MAG_W-1];
      mag_q  <= sweep[MAG_W-1] ? MAG_W'(-sweep) : MAG_W'(sweep);
    end
  end

  // direction times radius, rounded to Q16
  logic signed [49:0]        pmx, pmy, pnx, pny;
  logic signed [SCALE_W-1:0] mx_q, my_q, nx_q, ny_q;

  always_comb begin
    pmx = dx_q * $signed({1'b0, rmaj_q});
    pmy = dy_q * $signed({1'b0, rmaj_q});
    pnx = dx_q * $signed({1'b0, rmin_q});
    pny = dy_q * $signed({1'b0, rmin_q});
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_STEPS) begin
      mx_q <= SCALE_W'((pmx + 50'sd32768) >>> 16);
      my_q <= SCALE_W'((pmy + 50'sd32768) >>> 16);
      nx_q <= SCALE_W'((pnx + 50'sd32768) >>> 16);
      ny_q <= SCALE_W'((pny + 50'sd32768) >>> 16);
    end
  end

  // step count: smallest k >= 2 with k * 2pi >= mag * 2^14 * segments, clamped
  logic [ACC_W-1:0]   num, acc_q, acc_d;
  logic [STEPS_W-1:0] steps_q, steps_d;
  logic               steps_more;

  assign num = ACC_W'({27'(mag_q) * 27'(SEGMENTS_PER_TURN), 14'b0});
  assign steps_more = (acc_q < num) && (steps_q < STEPS_W'(MAX_STEPS));

  // quotient and remainder of mag / steps
  logic [6:0]       rem_q, rem_d, rem2;
  logic [MAG_W-1:0] quo_q, quo_d;
  logic [4:0]       dcnt_q, dcnt_d;
  logic             ge;
  logic             div_done;

  assign rem2 = {rem_q[5:0], quo_q[MAG_W-1]};
  assign ge   = rem2 >= {1'b0, steps_q};
  assign div_done = dcnt_q == 5'(MAG_W - 1);

  // point walk: off steps by q, running remainder r against 2*steps
  logic [MAG_W-1:0]   off_q, off_d;
  logic [6:0]         r_q, r_d;
  logic [7:0]         r_sum;
  logic [6:0]         two_steps, r0;
  logic [STEPS_W-1:0] idx_q, idx_d, tag_q, tag_d;
  logic               issued_all_q, issued_all_d;
  logic               inflight_q, inflight_d;
  logic               issue;
  logic               res_valid;

  assign two_steps = {steps_q, 1'b0};
  assign r0        = {rem_q[5:0], 1'b0};
  assign r_sum     = {1'b0, r_q} + {1'b0, r0};
  assign issue = (state_q == ST_RUN) && !inflight_q && !out_valid_o && !issued_all_q;

  logic signed [ANGLE_W-1:0] angle;
  assign angle = sneg_q ? ANGLE_W'(a0_q) - ANGLE_W'({1'b0, off_q})
                        : ANGLE_W'(a0_q) + ANGLE_W'({1'b0, off_q});

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_STEPS;
      ST_STEPS: if (!steps_more) state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_RUN;
      ST_RUN:   if (out_acc && last_point_o) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    acc_d        = acc_q;
    steps_d      = steps_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    dcnt_d       = dcnt_q;
    off_d        = off_q;
    r_d          = r_q;
    idx_d        = idx_q;
    tag_d        = tag_q;
    issued_all_d = issued_all_q;
    inflight_d   = inflight_q;
    case (state_q)
      ST_IDLE: begin
        acc_d   = ACC_W'(2 * TWO_PI_Q30);
        steps_d = STEPS_W'(2);
      end
      ST_STEPS: begin
        if (steps_more) begin
          acc_d   = acc_q + ACC_W'(TWO_PI_Q30);
          steps_d = steps_q + 1'b1;
        end else begin
          rem_d  = '0;
          quo_d  = mag_q;
          dcnt_d = '0;
        end
      end
      ST_DIV: begin
        rem_d  = ge ? rem2 - {1'b0, steps_q} : rem2;
        quo_d  = {quo_q[MAG_W-2:0], ge};
        dcnt_d = dcnt_q + 1'b1;
        if (div_done) begin
          off_d        = '0;
          r_d          = {1'b0, steps_q};
          idx_d        = '0;
          issued_all_d = 1'b0;
          inflight_d   = 1'b0;
        end
      end
      ST_RUN: begin
        if (issue) begin
          inflight_d = 1'b1;
          tag_d      = idx_q;
          idx_d      = idx_q + 1'b1;
          if (idx_q == steps_q) issued_all_d = 1'b1;
          if (r_sum >= {1'b0, two_steps}) begin
            r_d   = 7'(r_sum - {1'b0, two_steps});
            off_d = off_q + quo_q + 1'b1;
          end else begin
            r_d   = r_sum[6:0];
            off_d = off_q + quo_q;
          end
        end
        if (res_valid) inflight_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      issued_all_q <= 1'b0;
      inflight_q   <= 1'b0;
      dcnt_q       <= '0;
    end else begin
      state_q      <= state_d;
      issued_all_q <= issued_all_d;
      inflight_q   <= inflight_d;
      dcnt_q       <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    steps_q <= steps_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    off_q   <= off_d;
    r_q     <= r_d;
    idx_q   <= idx_d;
    tag_q   <= tag_d;
  end

  assign in_stall_o = state_q != ST_IDLE;

  // sine and cosine
  logic                     trig_valid;
  logic signed [TRIG_W-1:0] cos24, sin24;

  eat_cordic_chain #(.ROTATION_STEPS(ROTATION_STEPS)) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(issue),
    .angle_i(angle),
    .valid_o(trig_valid),
    .cos_o  (cos24),
    .sin_o  (sin24)
  );

  // products, then sum with rounding and saturation
  logic               prod_valid_q;
  logic signed [60:0] pa_q, pb_q, pc_q, pd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else begin
      prod_valid_q <= trig_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q <= mx_q * cos24;
    pb_q <= ny_q * sin24;
    pc_q <= my_q * cos24;
    pd_q <= nx_q * sin24;
  end

  logic signed [63:0] sx, sy;
  logic signed [39:0] rx, ry;

  assign res_valid = prod_valid_q;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  always_comb begin
    sx = ({{8{cx_q[31]}}, cx_q, 24'b0}) + 64'(pa_q) - 64'(pb_q);
    sy = ({{8{cy_q[31]}}, cy_q, 24'b0}) + 64'(pc_q) + 64'(pd_q);
    rx = 40'((sx + 64'sd8388608) >>> 24);
    ry = 40'((sy + 64'sd8388608) >>> 24);
  end

  logic               out_valid_q;
  logic signed [31:0] px_q, py_q;
  logic [5:0]         pidx_q;
  logic               plast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      px_q    <= sat32(rx);
      py_q    <= sat32(ry);
      pidx_q  <= tag_q;
      plast_q <= tag_q == steps_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign point_x_o     = px_q;
  assign point_y_o     = py_q;
  assign point_index_o = pidx_q;
  assign last_point_o  = plast_q;

  // checks
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!out_valid_q && !inflight_q))
    else $error("point pending while idle");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> !issue)
    else $error("two points issued back to back");

  a_steps_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (steps_q >= STEPS_W'(2) && steps_q <= STEPS_W'(MAX_STEPS)))
    else $error("step count out of range");

  a_result_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (inflight_q && !out_valid_q))
    else $error("result without a point in flight");

endmodule

// ===== hdl/eat_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// eat_cordic_cell
// One rotation-mode cordic iteration, registered, handing x/y/z on.
// ----------------------------------------------------------------------------
module eat_cordic_cell import eat_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  eat_rot_t rot_i,
  output eat_rot_t rot_o
);

  localparam logic signed [ROT_W-1:0] ATAN = ROT_W'(atan_q30(IDX));

  logic signed [ROT_W-1:0] xs, ys;
  eat_rot_t rot_d, rot_q;

  assign xs = rot_i.x >>> IDX;
  assign ys = rot_i.y >>> IDX;

  always_comb begin
    rot_d = rot_i;
    if (!rot_i.z[ROT_W-1]) begin
      rot_d.x = rot_i.x - ys;
      rot_d.y = rot_i.y + xs;
      rot_d.z = rot_i.z - ATAN;
    end else begin
      rot_d.x = rot_i.x + ys;
      rot_d.y = rot_i.y - xs;
      rot_d.z = rot_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q <= '0;
    end else begin
      rot_q <= rot_d;
    end
  end

  assign rot_o = rot_q;

endmodule

// ===== hdl/eat_cordic_chain.sv =====
// ----------------------------------------------------------------------------
// eat_cordic_chain
// Angle reduction into +-pi/2, a row of cordic cells, and Q24 rounding.
// ----------------------------------------------------------------------------
module eat_cordic_chain import eat_pkg::*; #(
  parameter int ROTATION_STEPS = ROTATION_STEPS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic signed [ANGLE_W-1:0] angle_i,
  output logic                     valid_o,
  output logic signed [TRIG_W-1:0] cos_o,
  output logic signed [TRIG_W-1:0] sin_o
);

  eat_rot_t rot [0:ROTATION_STEPS];
  eat_rot_t front_q;

  logic signed [35:0] z_full, z_wrap, z_fold;
  logic               fold;

  always_comb begin
    z_full = {angle_i, 14'b0};
    if (z_full > PI_Q30) begin
      z_wrap = z_full - TWO_PI_Q30;
    end else if (z_full <= -PI_Q30) begin
      z_wrap = z_full + TWO_PI_Q30;
    end else begin
      z_wrap = z_full;
    end
    fold = 1'b1;
    if (z_wrap > HALF_PI_Q30) begin
      z_fold = z_wrap - PI_Q30;
    end else if (z_wrap < -HALF_PI_Q30) begin
      z_fold = z_wrap + PI_Q30;
    end else begin
      z_fold = z_wrap;
      fold   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
    end else begin
      front_q.valid <= valid_i;
      front_q.neg   <= fold;
      front_q.x     <= CORDIC_GAIN_Q30;
      front_q.y     <= '0;
      front_q.z     <= ROT_W'(z_fold);
    end
  end

  assign rot[0] = front_q;

  for (genvar g = 0; g < ROTATION_STEPS; g++) begin : g_cell
    eat_cordic_cell #(.IDX(g)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .rot_i (rot[g]),
      .rot_o (rot[g+1])
    );
  end

  // undo the fold and round Q30 to Q24, half up
  eat_rot_t                last;
  logic signed [ROT_W:0]   c_s, s_s;
  logic                    valid_q;
  logic signed [TRIG_W-1:0] cos_q, sin_q;

  assign last = rot[ROTATION_STEPS];

  always_comb begin
    c_s = last.neg ? -(ROT_W+1)'(last.x) : (ROT_W+1)'(last.x);
    s_s = last.neg ? -(ROT_W+1)'(last.y) : (ROT_W+1)'(last.y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q <= TRIG_W'((c_s + 34'sd32) >>> 6);
    sin_q <= TRIG_W'((s_s + 34'sd32) >>> 6);
  end

  assign valid_o = valid_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;

endmodule
